// ===== rtl/kvlp_pkg.sv =====
// Shared types and constants for the key/value label parser.
// Holds field widths, character codes, role and status codes, and the hash step.
// No dependencies; imported by every module of the block.
package kvlp_pkg;

    // Field and register widths
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PAIR_W      = 5;
    localparam int unsigned KEY_LIM_W   = 7;
    localparam int unsigned VAL_LIM_W   = 9;
    localparam int unsigned LABEL_LIM_W = 13;
    localparam int unsigned LEN_W       = 12;
    localparam int unsigned COUNT_W     = 13;
    localparam int unsigned HASH_W      = 32;
    localparam int unsigned HASH_SHIFT  = 5;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_ADDR_W  = 4;
    localparam int unsigned REG_IDX_W   = 2;

    // Hash seed and characters of interest
    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam logic [BYTE_W-1:0] CHAR_EQ   = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;

    // Register reset values
    localparam logic [PAIR_W-1:0]      PAIR_LIMIT_RST  = 5'd16;
    localparam logic [KEY_LIM_W-1:0]   KEY_LIMIT_RST   = 7'd64;
    localparam logic [VAL_LIM_W-1:0]   VAL_LIMIT_RST   = 9'd256;
    localparam logic [LABEL_LIM_W-1:0] LABEL_LIMIT_RST = 13'd4096;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_PAIR_LIMIT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LIMIT   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VAL_LIMIT   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LABEL_LIMIT = 2'd3;

    typedef enum logic [1:0] {
        ROLE_KEY     = 2'd0,
        ROLE_SEP     = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_NEWLINE = 2'd3
    } role_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_PAIRS  = 2'd2
    } status_t;

    typedef struct packed {
        logic [LABEL_LIM_W-1:0] label_length_limit;
        logic [VAL_LIM_W-1:0]   value_length_limit;
        logic [KEY_LIM_W-1:0]   key_length_limit;
        logic [PAIR_W-1:0]      pair_limit;
    } kvlp_cfg_t;

    typedef struct packed {
        role_t               byte_role;
        logic [PAIR_W-1:0]   pair_number;
        logic [LEN_W-1:0]    char_position;
        logic [BYTE_W-1:0]   byte_echo;
        logic                done_res;
        status_t             status;
        logic [PAIR_W-1:0]   pairs_found;
        logic [HASH_W-1:0]   label_hash;
    } kvlp_res_t;

    // djb2 step: h * 33 + b as a shift and two adds
    function automatic logic [HASH_W-1:0] djb2_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        return (h << HASH_SHIFT) + h + {{(HASH_W-BYTE_W){1'b0}}, b};
    endfunction

endpackage

// ===== rtl/kvlp_cfg_regs.sv =====
// Configuration register file of the label parser, on an APB-style port.
// Four limit registers at byte addresses 0, 4, 8 and 12; depends on kvlp_pkg.
module kvlp_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kvlp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [kvlp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [kvlp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output kvlp_pkg::kvlp_cfg_t               cfg
);
    import kvlp_pkg::*;

    kvlp_cfg_t           cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    // Write the addressed register, truncating to its width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pair_limit         <= PAIR_LIMIT_RST;
            cfg_reg.key_length_limit   <= KEY_LIMIT_RST;
            cfg_reg.value_length_limit <= VAL_LIMIT_RST;
            cfg_reg.label_length_limit <= LABEL_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PAIR_LIMIT:  cfg_reg.pair_limit         <= pwdata[PAIR_W-1:0];
                REG_KEY_LIMIT:   cfg_reg.key_length_limit   <= pwdata[KEY_LIM_W-1:0];
                REG_VAL_LIMIT:   cfg_reg.value_length_limit <= pwdata[VAL_LIM_W-1:0];
                REG_LABEL_LIMIT: cfg_reg.label_length_limit <= pwdata[LABEL_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero extended
    always_comb begin
        case (reg_idx)
            REG_PAIR_LIMIT:
                prdata = {{(CFG_DATA_W-PAIR_W){1'b0}}, cfg_reg.pair_limit};
            REG_KEY_LIMIT:
                prdata = {{(CFG_DATA_W-KEY_LIM_W){1'b0}}, cfg_reg.key_length_limit};
            REG_VAL_LIMIT:
                prdata = {{(CFG_DATA_W-VAL_LIM_W){1'b0}}, cfg_reg.value_length_limit};
            REG_LABEL_LIMIT:
                prdata = {{(CFG_DATA_W-LABEL_LIM_W){1'b0}}, cfg_reg.label_length_limit};
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/kvlp_core.sv =====
// Parse datapath of the label parser: input register, per-byte state update
// and result register. Depends on kvlp_pkg.
module kvlp_core #(
    parameter int MAX_PAIRS       = 16,
    parameter int MAX_KEY_BYTES   = 64,
    parameter int MAX_VALUE_BYTES = 256,
    parameter int MAX_LABEL_BYTES = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  kvlp_pkg::kvlp_cfg_t             cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [kvlp_pkg::BYTE_W-1:0]     in_byte,
    input  logic                            in_last,
    output logic                            res_valid,
    input  logic                            res_ready,
    output kvlp_pkg::kvlp_res_t             res
);
    import kvlp_pkg::*;

    // Parameter caps at what each register can express
    localparam int PAIR_CAP_I  = (MAX_PAIRS > 2**PAIR_W - 1) ? 2**PAIR_W - 1 : MAX_PAIRS;
    localparam int KEY_CAP_I   = (MAX_KEY_BYTES > 2**KEY_LIM_W - 1) ?
                                 2**KEY_LIM_W - 1 : MAX_KEY_BYTES;
    localparam int VAL_CAP_I   = (MAX_VALUE_BYTES > 2**VAL_LIM_W - 1) ?
                                 2**VAL_LIM_W - 1 : MAX_VALUE_BYTES;
    localparam int LABEL_CAP_I = (MAX_LABEL_BYTES > 2**LABEL_LIM_W - 1) ?
                                 2**LABEL_LIM_W - 1 : MAX_LABEL_BYTES;
    localparam logic [PAIR_W-1:0]      PAIR_CAP  = PAIR_W'(PAIR_CAP_I);
    localparam logic [KEY_LIM_W-1:0]   KEY_CAP   = KEY_LIM_W'(KEY_CAP_I);
    localparam logic [VAL_LIM_W-1:0]   VAL_CAP   = VAL_LIM_W'(VAL_CAP_I);
    localparam logic [LABEL_LIM_W-1:0] LABEL_CAP = LABEL_LIM_W'(LABEL_CAP_I);

    // Input stage
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_last_reg;

    // Parse state
    logic [HASH_W-1:0]   hash_reg,      hash_next;
    logic                stopped_reg,   stopped_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;
    logic [PAIR_W-1:0]   pairs_reg,     pairs_next;
    logic                in_value_reg,  in_value_next;
    logic [LEN_W-1:0]    key_len_reg,   key_len_next;
    logic [LEN_W-1:0]    val_len_reg,   val_len_next;
    status_t             err_reg,       err_next;
    logic                over_reg,      over_next;

    // Result stage
    logic                res_valid_reg;
    kvlp_res_t           res_reg,       res_next;

    logic                advance;
    logic                line_end;
    logic [LEN_W-1:0]    pos;
    role_t               role;
    logic [PAIR_W-1:0]   pair_max;
    logic [KEY_LIM_W-1:0] key_max;
    logic [VAL_LIM_W-1:0] val_max;
    logic [LABEL_LIM_W-1:0] label_max;

    assign advance   = !res_valid_reg || res_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Effective limits
    assign pair_max  = (cfg.pair_limit < PAIR_CAP) ? cfg.pair_limit : PAIR_CAP;
    assign key_max   = (cfg.key_length_limit < KEY_CAP) ? cfg.key_length_limit : KEY_CAP;
    assign val_max   = (cfg.value_length_limit < VAL_CAP) ? cfg.value_length_limit : VAL_CAP;
    assign label_max = (cfg.label_length_limit < LABEL_CAP) ?
                       cfg.label_length_limit : LABEL_CAP;

    // Per-byte update: length check, hash, role, line close, result
    always_comb begin
        over_next     = over_reg | (count_reg >= label_max);
        count_next    = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        hash_next     = hash_reg;
        stopped_next  = stopped_reg;
        in_value_next = in_value_reg;
        key_len_next  = key_len_reg;
        val_len_next  = val_len_reg;
        pairs_next    = pairs_reg;
        err_next      = err_reg;
        pos           = '0;
        line_end      = in_last_reg;

        // Hash bytes up to the first NUL
        if (!stopped_reg) begin
            if (in_byte_reg == CHAR_NUL) begin
                stopped_next = 1'b1;
            end else begin
                hash_next = djb2_step(hash_reg, in_byte_reg);
            end
        end

        // Classify the byte
        if (in_byte_reg == CHAR_LF) begin
            role     = ROLE_NEWLINE;
            line_end = 1'b1;
        end else if (!in_value_reg && in_byte_reg == CHAR_EQ) begin
            role          = ROLE_SEP;
            in_value_next = 1'b1;
        end else if (!in_value_reg) begin
            role = ROLE_KEY;
            pos  = key_len_reg;
            if (key_len_reg != '1) begin
                key_len_next = key_len_reg + 1'b1;
            end
        end else begin
            role = ROLE_VALUE;
            pos  = val_len_reg;
            if (val_len_reg != '1) begin
                val_len_next = val_len_reg + 1'b1;
            end
        end

        // Close a nonempty line: first error wins, else accept the pair
        if (line_end) begin
            if ((key_len_next != '0 || in_value_next) && err_reg == STATUS_OK) begin
                if (pairs_reg >= pair_max) begin
                    err_next = STATUS_PAIRS;
                end else if (!in_value_next) begin
                    err_next = STATUS_FORMAT;
                end else if (key_len_next == '0 ||
                             key_len_next >= {{(LEN_W-KEY_LIM_W){1'b0}}, key_max}) begin
                    err_next = STATUS_FORMAT;
                end else if (val_len_next >= {{(LEN_W-VAL_LIM_W){1'b0}}, val_max}) begin
                    err_next = STATUS_FORMAT;
                end else begin
                    pairs_next = pairs_reg + 1'b1;
                end
            end
            in_value_next = 1'b0;
            key_len_next  = '0;
            val_len_next  = '0;
        end

        // Build the result
        res_next.byte_role     = role;
        res_next.pair_number   = pairs_reg;
        res_next.char_position = pos;
        res_next.byte_echo     = in_byte_reg;
        res_next.done_res      = in_last_reg;
        if (in_last_reg) begin
            res_next.status      = over_next ? STATUS_FORMAT : err_next;
            res_next.pairs_found = over_next ? '0 : pairs_next;
            res_next.label_hash  = over_next ? '0 : hash_next;
        end else begin
            res_next.status      = STATUS_OK;
            res_next.pairs_found = pairs_next;
            res_next.label_hash  = '0;
        end

        // End of label: drop all parse state
        if (in_last_reg) begin
            hash_next     = HASH_SEED;
            stopped_next  = 1'b0;
            count_next    = '0;
            pairs_next    = '0;
            in_value_next = 1'b0;
            key_len_next  = '0;
            val_len_next  = '0;
            err_next      = STATUS_OK;
            over_next     = 1'b0;
        end
    end

    // Input register: load whenever there is room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    // Parse state and result valid: advance when the result slot frees
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            hash_reg      <= HASH_SEED;
            stopped_reg   <= 1'b0;
            count_reg     <= '0;
            pairs_reg     <= '0;
            in_value_reg  <= 1'b0;
            key_len_reg   <= '0;
            val_len_reg   <= '0;
            err_reg       <= STATUS_OK;
            over_reg      <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                hash_reg     <= hash_next;
                stopped_reg  <= stopped_next;
                count_reg    <= count_next;
                pairs_reg    <= pairs_next;
                in_value_reg <= in_value_next;
                key_len_reg  <= key_len_next;
                val_len_reg  <= val_len_next;
                err_reg      <= err_next;
                over_reg     <= over_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    // Status and hash appear only on the final result
    a_summary_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !res_reg.done_res) |->
            (res_reg.status == STATUS_OK && res_reg.label_hash == '0))
        else $error("summary fields set on a non-final result");

    // Separators and newlines carry no offset
    a_marker_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && (res_reg.byte_role == ROLE_SEP ||
                           res_reg.byte_role == ROLE_NEWLINE)) |->
            (res_reg.char_position == '0))
        else $error("separator or newline with nonzero position");

    // A finished label leaves the parse state at reset values
    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && in_last_reg) |=>
            (count_reg == '0 && pairs_reg == '0 && err_reg == STATUS_OK &&
             !over_reg && hash_reg == HASH_SEED))
        else $error("parse state not cleared after the last byte");

    // A blocked byte stays in the input register
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=>
            (in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg)))
        else $error("input byte lost while the result stage was stalled");

endmodule

// ===== rtl/key_value_label_parser.sv =====
// Top level of the key/value label parser: stream ports, APB configuration.
// Instantiates kvlp_cfg_regs and kvlp_core; depends on kvlp_pkg.
//
//  Port group   Direction  Carries
//  s_*          in         one label byte per transfer, tlast on the final byte
//  m_*          out        one tagged result per input byte, tlast on the final one
//  APB          in/out     limit registers: pairs, key, value, label length
//
// Throughput is one byte per cycle while m_tready allows; a byte passes the input
// register, the combinational update (hash shift-add) and the result register.
// Reset is synchronous on aresetn low: parse state cleared, limits to defaults.
// A stalled m_ side holds the result and the byte behind it; s_tready drops
// only when both registers are full and m_tready is low.
module key_value_label_parser #(
    parameter int MAX_PAIRS       = 16,
    parameter int MAX_KEY_BYTES   = 64,
    parameter int MAX_VALUE_BYTES = 256,
    parameter int MAX_LABEL_BYTES = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] data_byte
    input  logic                            s_tlast,  // last_byte
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,  // [4:0] pair_number,
                                                      // [16:5] char_position,
                                                      // [24:17] byte_echo,
                                                      // [26:25] status,
                                                      // [31:27] pairs_found,
                                                      // [63:32] label_hash
    output logic [1:0]                      m_tuser,  // [1:0] byte_role
    output logic                            m_tlast,  // done_res
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kvlp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [kvlp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [kvlp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import kvlp_pkg::*;

    kvlp_cfg_t cfg;
    kvlp_res_t res;

    kvlp_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kvlp_core #(
        .MAX_PAIRS       (MAX_PAIRS),
        .MAX_KEY_BYTES   (MAX_KEY_BYTES),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES),
        .MAX_LABEL_BYTES (MAX_LABEL_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {res.label_hash, res.pairs_found, res.status,
                      res.byte_echo, res.char_position, res.pair_number};
    assign m_tuser = res.byte_role;
    assign m_tlast = res.done_res;

endmodule

// ===== test/key_value_label_parser_test.sv =====
// Self-checking testbench for key_value_label_parser: label bytes in, tagged bytes out.
// Predicts every tag, pair count and hash in a tracker class and drives APB and stream ports.
// Depends on kvlp_pkg and the RTL top level only.
module key_value_label_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kvlp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_PAIRS    = 16;
    localparam int MAX_KEY      = 64;
    localparam int MAX_VALUE    = 256;
    localparam int MAX_LABEL    = 4096;
    localparam int LEN_CAP      = 4095;
    localparam int COUNT_CAP    = 8191;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_ITEMS  = 90;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 3000;

    function automatic int unsigned clip(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Tracks the parse state and holds the tags expected back from the block
    class label_tag_tracker;
        kvlp_res_t              pending_tags[$];
        logic [PAIR_W-1:0]      pair_limit;
        logic [KEY_LIM_W-1:0]   key_limit;
        logic [VAL_LIM_W-1:0]   value_limit;
        logic [LABEL_LIM_W-1:0] label_limit;
        logic [HASH_W-1:0]      running_hash;
        logic                   hash_stopped;
        logic                   in_value;
        logic                   over_length;
        logic [PAIR_W-1:0]      pair_count;
        status_t                error_code;
        int unsigned            byte_count;
        int unsigned            key_len;
        int unsigned            value_len;
        int                     tag_errors;

        function new();
            pair_limit  = PAIR_LIMIT_RST;
            key_limit   = KEY_LIMIT_RST;
            value_limit = VAL_LIMIT_RST;
            label_limit = LABEL_LIMIT_RST;
            tag_errors  = 0;
            clear_parse();
        endfunction

        function void set_limit(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PAIR_LIMIT:  pair_limit  = value[PAIR_W-1:0];
                REG_KEY_LIMIT:   key_limit   = value[KEY_LIM_W-1:0];
                REG_VAL_LIMIT:   value_limit = value[VAL_LIM_W-1:0];
                REG_LABEL_LIMIT: label_limit = value[LABEL_LIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void clear_parse();
            running_hash = HASH_SEED;
            hash_stopped = 1'b0;
            in_value     = 1'b0;
            over_length  = 1'b0;
            pair_count   = '0;
            error_code   = STATUS_OK;
            byte_count   = 0;
            key_len      = 0;
            value_len    = 0;
        endfunction

        // Judge a finished nonempty line; the first error sticks
        function void close_line();
            if ((key_len != 0 || in_value) && error_code == STATUS_OK) begin
                if (pair_count >= clip(pair_limit, MAX_PAIRS))
                    error_code = STATUS_PAIRS;
                else if (!in_value)
                    error_code = STATUS_FORMAT;
                else if (key_len == 0 || key_len >= clip(key_limit, MAX_KEY))
                    error_code = STATUS_FORMAT;
                else if (value_len >= clip(value_limit, MAX_VALUE))
                    error_code = STATUS_FORMAT;
                else
                    pair_count = pair_count + 1'b1;
            end
            in_value  = 1'b0;
            key_len   = 0;
            value_len = 0;
        endfunction

        // Advance the parse by one accepted byte and queue its tag
        function void take_byte(logic [7:0] b, logic last);
            kvlp_res_t want;
            logic      line_end;
            want = '0;
            line_end = last;
            if (byte_count >= clip(label_limit, MAX_LABEL))
                over_length = 1'b1;
            if (byte_count < COUNT_CAP)
                byte_count++;
            if (!hash_stopped) begin
                if (b == CHAR_NUL)
                    hash_stopped = 1'b1;
                else
                    running_hash = running_hash * 32'd33 + {24'd0, b};
            end
            if (b == CHAR_LF) begin
                want.byte_role = ROLE_NEWLINE;
                line_end = 1'b1;
            end else if (!in_value && b == CHAR_EQ) begin
                want.byte_role = ROLE_SEP;
                in_value = 1'b1;
            end else if (!in_value) begin
                want.byte_role = ROLE_KEY;
                want.char_position = key_len[LEN_W-1:0];
                if (key_len < LEN_CAP)
                    key_len++;
            end else begin
                want.byte_role = ROLE_VALUE;
                want.char_position = value_len[LEN_W-1:0];
                if (value_len < LEN_CAP)
                    value_len++;
            end
            want.pair_number = pair_count;
            if (line_end)
                close_line();
            want.byte_echo = b;
            want.done_res  = last;
            if (last) begin
                // a label over the length limit reports format error and blanks the rest
                want.status      = over_length ? STATUS_FORMAT : error_code;
                want.pairs_found = over_length ? '0 : pair_count;
                want.label_hash  = over_length ? '0 : running_hash;
                clear_parse();
            end else begin
                want.status      = STATUS_OK;
                want.pairs_found = pair_count;
                want.label_hash  = '0;
            end
            pending_tags.push_back(want);
        endfunction

        // Print one tag on a single line behind a short label
        function void show_tag(string tag, kvlp_res_t r);
            $display("%s role %0d pair %0d pos %0d byte %02h last %0d st %0d found %0d hash %08h",
                     tag, r.byte_role, r.pair_number, r.char_position, r.byte_echo,
                     r.done_res, r.status, r.pairs_found, r.label_hash);
        endfunction

        function void check_tags(kvlp_res_t got);
            kvlp_res_t want;
            if (pending_tags.size() == 0) begin
                tag_errors++;
                if (tag_errors <= REPORT_LIMIT)
                    $display("unexpected result transfer: byte %02h", got.byte_echo);
                return;
            end
            want = pending_tags.pop_front();
            if (got.byte_role !== want.byte_role || got.pair_number !== want.pair_number ||
                got.char_position !== want.char_position ||
                got.byte_echo !== want.byte_echo || got.done_res !== want.done_res ||
                got.status !== want.status || got.pairs_found !== want.pairs_found ||
                got.label_hash !== want.label_hash) begin
                tag_errors++;
                if (tag_errors <= REPORT_LIMIT) begin
                    show_tag("mismatch exp:", want);
                    show_tag("         got:", got);
                end
            end
        endfunction

        function int tags_pending();
            return pending_tags.size();
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // [7:0] data_byte
    logic                  s_tlast  = 1'b0; // last_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;         // [4:0] pair_number, [16:5] char_position,
                                            // [24:17] byte_echo, [26:25] status,
                                            // [31:27] pairs_found, [63:32] label_hash
    logic [1:0]            m_tuser;         // [1:0] byte_role
    logic                  m_tlast;         // done_res
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    label_tag_tracker tracker;
    kvlp_res_t        observed;
    logic [7:0]       label_q[$];
    int               send_idle    = 0;
    int               recv_stall   = 0;
    int               bytes_sent   = 0;
    int               quiet_cycles = 0;

    key_value_label_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Check each result transfer, count quiet cycles, stall the result side at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            observed.byte_role     = role_t'(m_tuser);
            observed.pair_number   = m_tdata[4:0];
            observed.char_position = m_tdata[16:5];
            observed.byte_echo     = m_tdata[24:17];
            observed.status        = status_t'(m_tdata[26:25]);
            observed.pairs_found   = m_tdata[31:27];
            observed.label_hash    = m_tdata[63:32];
            observed.done_res      = m_tlast;
            tracker.check_tags(observed);
        end
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("** key_value_label_parser: FAILED **");
        $finish;
    end

    function automatic logic [7:0] key_byte();
        logic [7:0] b;
        if ($urandom_range(0, 11) == 0)
            return CHAR_NUL;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF || b == CHAR_EQ);
        return b;
    endfunction

    function automatic logic [7:0] value_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0: return CHAR_NUL;
            1: return CHAR_EQ;
            default: ;
        endcase
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return CHAR_LF;
            1: return CHAR_EQ;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        tracker.set_limit(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write all four limits; fill the unused upper bits with junk to exercise masking
    task automatic configure(int unsigned pairs, int unsigned keys, int unsigned values,
                             int unsigned label);
        apb_write(REG_PAIR_LIMIT,  ($urandom() << PAIR_W) | pairs);
        apb_write(REG_KEY_LIMIT,   ($urandom() << KEY_LIM_W) | keys);
        apb_write(REG_VAL_LIMIT,   ($urandom() << VAL_LIM_W) | values);
        apb_write(REG_LABEL_LIMIT, ($urandom() << LABEL_LIM_W) | label);
    endtask

    // Offer one byte, hold it until the transfer, then idle at random
    task automatic send_byte(logic [7:0] b, logic last);
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        tracker.take_byte(b, last);
        bytes_sent++;
        if ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
    endtask

    task automatic send_label();
        for (int i = 0; i < label_q.size(); i++)
            send_byte(label_q[i], i == label_q.size() - 1);
        label_q.delete();
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            label_q.push_back(s[i]);
    endtask

    // Hold the sender until every tag is back, then let the pipeline settle
    task automatic drain();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (tracker.tags_pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Build a label: mostly key=value lines near the limits, some broken lines and noise
    task automatic compose_label();
        int unsigned pmax, kmax, vmax, key_hi, val_hi, lines, klen, vlen;
        int          kind;
        pmax = clip(tracker.pair_limit, MAX_PAIRS);
        kmax = clip(tracker.key_limit, MAX_KEY);
        vmax = clip(tracker.value_limit, MAX_VALUE);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) label_q.push_back(noise_byte());
        end else begin
            lines  = $urandom_range(1, clip(pmax, 5) + 1);
            key_hi = (kmax > 1) ? clip(kmax - 1, 6) : 1;
            val_hi = (vmax > 0) ? clip(vmax - 1, 6) : 0;
            for (int i = 0; i < lines; i++) begin
                kind = $urandom_range(0, 15);
                klen = $urandom_range(1, key_hi);
                vlen = $urandom_range(0, val_hi);
                case (kind)
                    0, 2: klen = 0;
                    3: begin
                        klen = (kmax == 0) ? 1 : clip(kmax, 9);
                        if (klen > 1 && $urandom_range(0, 1) == 1)
                            klen--;
                    end
                    4: begin
                        vlen = clip(vmax, 9);
                        if (vlen > 0 && $urandom_range(0, 1) == 1)
                            vlen--;
                    end
                    default: ;
                endcase
                repeat (klen) label_q.push_back(key_byte());
                // an empty line and a line with no separator stop after the key
                if (kind != 0 && kind != 1) begin
                    label_q.push_back(CHAR_EQ);
                    repeat (vlen) label_q.push_back(value_byte());
                end
                if (i + 1 < lines)
                    label_q.push_back(CHAR_LF);
            end
            if ($urandom_range(0, 3) == 0)
                label_q.push_back(CHAR_LF);
            if (label_q.size() == 0)
                label_q.push_back(CHAR_LF);
        end
    endtask

    task automatic run_phase(int send_pct, int stall_pct);
        int start;
        send_idle  = send_pct;
        recv_stall = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_ITEMS / 2) begin
            compose_label();
            send_label();
        end
        // pause the sender mid-phase until the block has emptied
        drain();
        while (bytes_sent - start < PHASE_ITEMS) begin
            compose_label();
            send_label();
        end
        drain();
    endtask

    initial begin
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed labels under tight limits: two pairs, key below 4, value below 3, 8 bytes
        configure(2, 4, 3, 8);
        // later '=' in a value, empty line, NUL key byte stopping the hash, 0xFF value byte
        push_text("k==\n\n");
        label_q.push_back(CHAR_NUL);
        label_q.push_back(CHAR_EQ);
        label_q.push_back(8'hFF);
        send_label();
        // empty key
        push_text("=1");
        send_label();
        // no separator
        push_text("x");
        send_label();
        // value too long
        push_text("a=123");
        send_label();
        // label too long hides the pair-count error
        push_text("a=1\nb=2\nc");
        send_label();
        drain();

        // Random phases across limit settings and idle patterns
        configure(3, 6, 5, 40);
        run_phase(0, 0);
        configure(31, 127, 511, 8191);
        run_phase(81, 0);
        configure(1, 2, 1, 24);
        run_phase(0, 81);
        configure(0, 0, 0, 4095);
        run_phase(6, 6);
        configure(16, 64, 256, 0);
        run_phase(0, 0);

        if (tracker.tag_errors == 0 && tracker.tags_pending() == 0)
            $display("** key_value_label_parser: PASSED **");
        else
            $display("** key_value_label_parser: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kvlp_pkg.sv
rtl/kvlp_cfg_regs.sv
rtl/kvlp_core.sv
rtl/key_value_label_parser.sv
test/key_value_label_parser_test.sv
